@@ rtl/sfbl_pkg.sv @@
package sfbl_pkg;

  localparam int SIZE_W        = 48;
  localparam int INDEX_W       = 32;
  localparam int SFBL_CAPACITY = 64;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_POP_FRONT = 2'd1,
    REQ_POP_BACK  = 2'd2,
    REQ_REMOVE    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [INDEX_W-1:0] index;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } cell_data_t;

  // one-hot in practice: at most one member set per cell per cycle
  typedef struct packed {
    logic take_left;
    logic take_new;
    logic take_right;
    logic clear;
  } cell_cmd_t;

  typedef struct packed {
    logic ahead;   // new entry belongs at or ahead of this slot
    logic match;   // slot holds the index being searched for
    logic tail;    // last occupied slot
  } cell_flags_t;

endpackage

@@ rtl/sfbl_req_if.sv @@
interface sfbl_req_if import sfbl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [SIZE_W-1:0]  block_size;
  logic [INDEX_W-1:0] entry_index;

  modport source (output valid, output req_type, output block_size, output entry_index,
                  input ready);
  modport sink   (input valid, input req_type, input block_size, input entry_index,
                  output ready);
endinterface

@@ rtl/sfbl_rsp_if.sv @@
interface sfbl_rsp_if import sfbl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [SIZE_W-1:0]  out_size;
  logic [INDEX_W-1:0] out_index;

  modport source (output valid, output status, output out_size, output out_index,
                  input ready);
  modport sink   (input valid, input status, input out_size, input out_index,
                  output ready);
endinterface

@@ rtl/sfbl_cell.sv @@
module sfbl_cell import sfbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               capture,
  input  logic [SIZE_W-1:0]  key_size,
  input  logic [INDEX_W-1:0] key_index,
  input  entry_t             new_ent,
  input  cell_cmd_t          cmd,
  input  cell_data_t         left,
  input  cell_data_t         right,
  output cell_data_t         cur,
  output cell_flags_t        flags
);

  logic        valid;
  entry_t      ent;
  cell_flags_t flags_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.take_left) begin
      valid <= left.valid;
    end else if (cmd.take_new) begin
      valid <= 1'b1;
    end else if (cmd.take_right) begin
      valid <= right.valid;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_left) begin
      ent <= left.ent;
    end else if (cmd.take_new) begin
      ent <= new_ent;
    end else if (cmd.take_right) begin
      ent <= right.ent;
    end
  end

  // zero-size entries go ahead of existing zeros, nonzero ones behind equals
  always_ff @(posedge clk) begin
    if (capture) begin
      flags_q.ahead  <= !valid || (ent.size < key_size) ||
                        ((key_size == '0) && (ent.size == '0));
      flags_q.match  <= valid && (ent.index == key_index);
      flags_q.tail   <= valid && !right.valid;
    end
  end

  assign cur.valid = valid;
  assign cur.ent   = ent;
  assign flags     = flags_q;

endmodule

@@ rtl/sorted_free_block_list.sv @@
// channel | dir | handshake     | word
// req     | in  | valid / ready | req_type, block_size, entry_index
// rsp     | out | valid / ready | status, out_size, out_index
//
// Every request passes through S_IDLE and S_APPLY: the cells latch their compare
// flags as the request is accepted in S_IDLE, and in S_APPLY the whole row shifts
// or loads and the response register is loaded; no request is taken in S_APPLY.
// Reset empties the table at once (cell valid bits); no clearing pass.
// A stalled response holds req.ready low until it is taken.
module sorted_free_block_list import sfbl_pkg::*; #(
  parameter int CAPACITY = SFBL_CAPACITY
) (
  input  logic    clk,
  input  logic    rst,
  sfbl_req_if.sink   req,
  sfbl_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  req_type_t         op;
  entry_t            op_ent;
  logic              accept;

  cell_data_t        cell_d   [CAPACITY];
  cell_flags_t       cell_f   [CAPACITY];
  cell_cmd_t         cell_c   [CAPACITY];

  logic [CAPACITY-1:0] ahead_v, match_v, tail_v, valid_v, shift_v;
  logic                empty, full, found;
  status_t             status_next;
  entry_t              out_next, back_ent;

  assign req.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (accept) state <= S_APPLY;
        S_APPLY: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op           <= req_type_t'(req.req_type);
      op_ent.size  <= req.block_size;
      op_ent.index <= req.entry_index;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      cell_data_t left_d, right_d;
      if (g == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_d[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_d[g+1];
      end

      sfbl_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .capture   (accept),
        .key_size  (req.block_size),
        .key_index (req.entry_index),
        .new_ent   (op_ent),
        .cmd       (cell_c[g]),
        .left      (left_d),
        .right     (right_d),
        .cur       (cell_d[g]),
        .flags     (cell_f[g])
      );

      assign ahead_v[g]  = cell_f[g].ahead;
      assign match_v[g]  = cell_f[g].match;
      assign tail_v[g]   = cell_f[g].tail;
      assign valid_v[g]  = cell_d[g].valid;
    end
  endgenerate

  assign empty = (count == '0);
  assign full  = (count == CW'(CAPACITY));
  assign found = |match_v;
  // slots at or beyond the first match
  assign shift_v = ~((match_v - CAPACITY'(1)) & ~match_v);

  always_comb begin
    back_ent = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      back_ent = back_ent | (tail_v[k] ? cell_d[k].ent : '0);
    end
  end

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cell_c[k] = '0;
    end
    status_next = ST_OK;
    out_next    = '0;
    count_next  = count;
    if (state == S_APPLY) begin
      case (op)
        REQ_INSERT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            count_next = count + CW'(1);
            for (int k = 0; k < CAPACITY; k++) begin
              if (k == 0) begin
                cell_c[k].take_new = ahead_v[k];
              end else begin
                cell_c[k].take_left = ahead_v[k-1];
                cell_c[k].take_new  = ahead_v[k] && !ahead_v[k-1];
              end
            end
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            out_next   = cell_d[0].ent;
            count_next = count - CW'(1);
            for (int k = 0; k < CAPACITY; k++) begin
              cell_c[k].take_right = 1'b1;
            end
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            out_next   = back_ent;
            count_next = count - CW'(1);
            for (int k = 0; k < CAPACITY; k++) begin
              cell_c[k].clear = tail_v[k];
            end
          end
        end
        REQ_REMOVE: begin
          if (!found) begin
            status_next = ST_EMPTY;
          end else begin
            count_next = count - CW'(1);
            for (int k = 0; k < CAPACITY; k++) begin
              cell_c[k].take_right = shift_v[k];
            end
          end
        end
        default: status_next = ST_EMPTY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_APPLY) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      rsp.status    <= status_next;
      rsp.out_size  <= out_next.size;
      rsp.out_index <= out_next.index;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_v) == int'(count))
    else $error("occupied cells disagree with entry count");

  a_word_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 rsp.valid)
    else $error("accepted word produced no response");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while previous word still in the row");
`endif

endmodule

@@ sim/tb_sorted_free_block_list.sv @@
`timescale 1ns / 1ps

module tb_sorted_free_block_list;
  import sfbl_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  typedef struct {
    status_t             st;
    logic [SIZE_W-1:0]   sz;
    logic [INDEX_W-1:0]  idx;
  } outcome_t;

  class free_list_scoreboard;
    entry_t   slots[$];
    outcome_t outcome_q[$];
    int errors;
    int checked;
    int n_insert, n_full, n_pop, n_remove, n_miss, peak;

    function int pending();
      return outcome_q.size();
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endfunction

    // apply one accepted request word to the table copy and queue its outcome
    function void note_request(req_type_t rt, logic [SIZE_W-1:0] sz,
                               logic [INDEX_W-1:0] idx);
      outcome_t o;
      entry_t   e;
      int       pos;
      o.st  = ST_OK;
      o.sz  = '0;
      o.idx = '0;
      case (rt)
        REQ_INSERT: begin
          n_insert++;
          if (slots.size() >= SFBL_CAPACITY) begin
            o.st = ST_FULL;
            n_full++;
          end else begin
            pos = slots.size();
            // equal nonzero sizes queue behind; a zero goes ahead of the first zero
            for (int k = 0; k < slots.size(); k++) begin
              if (slots[k].size < sz || (sz == '0 && slots[k].size == '0)) begin
                pos = k;
                break;
              end
            end
            e.size  = sz;
            e.index = idx;
            slots.insert(pos, e);
            if (slots.size() > peak) peak = slots.size();
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          n_pop++;
          if (slots.size() == 0) begin
            o.st = ST_EMPTY;
            n_miss++;
          end else if (rt == REQ_POP_FRONT) begin
            e = slots.pop_front();
            o.sz  = e.size;
            o.idx = e.index;
          end else begin
            e = slots.pop_back();
            o.sz  = e.size;
            o.idx = e.index;
          end
        end
        default: begin
          n_remove++;
          o.st = ST_EMPTY;
          for (int k = 0; k < slots.size(); k++) begin
            if (slots[k].index == idx) begin
              slots.delete(k);
              o.st = ST_OK;
              break;
            end
          end
          if (o.st == ST_EMPTY) n_miss++;
        end
      endcase
      outcome_q.push_back(o);
    endfunction

    function void check_response(logic [1:0] st, logic [SIZE_W-1:0] sz,
                                 logic [INDEX_W-1:0] idx);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        report($sformatf("response word with none expected (status %0d)", st));
        return;
      end
      o = outcome_q.pop_front();
      checked++;
      if (st !== o.st)
        report($sformatf("resp %0d status %0d, expected %0d", checked, st, o.st));
      if (sz !== o.sz)
        report($sformatf("resp %0d out_size %h, expected %h", checked, sz, o.sz));
      if (idx !== o.idx)
        report($sformatf("resp %0d out_index %h, expected %h", checked, idx, o.idx));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle;
  int   burst_left;
  free_list_scoreboard sb;

  sfbl_req_if req_bus ();
  sfbl_rsp_if rsp_bus ();

  sorted_free_block_list u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycle, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_bus.valid && req_bus.ready)
        sb.note_request(req_type_t'(req_bus.req_type), req_bus.block_size,
                        req_bus.entry_index);
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_response(rsp_bus.status, rsp_bus.out_size, rsp_bus.out_index);
    end
  end

  // receiver back-pressure from one of four randomly chosen stall modes
  initial begin
    int stall_mode;
    int cnt;
    stall_mode = 0;
    cnt = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cnt++;
      if (cnt % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       rsp_bus.ready <= 1'b1;
        1:       rsp_bus.ready <= cnt[0];
        2:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_bus.ready <= (cnt[3:0] == 4'd0);
      endcase
    end
  end

  task automatic drive_item(input req_type_t rt, input logic [SIZE_W-1:0] sz,
                            input logic [INDEX_W-1:0] idx);
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= rt;
    req_bus.block_size  <= sz;
    req_bus.entry_index <= idx;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // burst pacing between words; a zero gap merges two bursts
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4: return SIZE_W'($urandom_range(1, 8));
      5:       return {SIZE_W{1'b1}};
      6:       return SIZE_W'({$urandom, $urandom});
      default: return SIZE_W'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index(input bit for_remove);
    if (for_remove && sb.slots.size() > 0 && $urandom_range(0, 9) < 6)
      return sb.slots[$urandom_range(0, sb.slots.size() - 1)].index;
    if ($urandom_range(0, 9) < 6) return INDEX_W'($urandom_range(0, 15));
    return $urandom;
  endfunction

  task automatic random_item(input req_type_t rt);
    drive_item(rt, pick_size(), pick_index(rt == REQ_REMOVE));
  endtask

  initial begin
    phase_t    phase;
    int        phase_len;
    int        sent;
    int        r;
    req_type_t rt;

    rst                 <= 1'b1;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= REQ_INSERT;
    req_bus.block_size  <= '0;
    req_bus.entry_index <= '0;
    burst_left          = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, ordering of ties and zeros, removes, extremes
    drive_item(REQ_POP_FRONT, '0, '0);
    drive_item(REQ_POP_BACK, {SIZE_W{1'b1}}, {INDEX_W{1'b1}});
    drive_item(REQ_REMOVE, '0, 32'd5);
    drive_item(REQ_INSERT, {SIZE_W{1'b1}}, {INDEX_W{1'b1}});
    drive_item(REQ_INSERT, '0, 32'd1);
    drive_item(REQ_INSERT, '0, 32'd2);
    drive_item(REQ_INSERT, 48'd100, 32'd3);
    drive_item(REQ_INSERT, 48'd100, 32'd4);
    drive_item(REQ_INSERT, 48'd100, 32'd3);
    drive_item(REQ_INSERT, 48'd1, 32'd0);
    drive_item(REQ_INSERT, 48'h8000_0000_0000, 32'h8000_0000);
    drive_item(REQ_REMOVE, '0, 32'd3);
    drive_item(REQ_REMOVE, '0, 32'd77);
    drive_item(REQ_POP_FRONT, '0, '0);
    drive_item(REQ_POP_BACK, '0, '0);
    drive_item(REQ_POP_BACK, '0, '0);
    drive_item(REQ_POP_FRONT, '0, '0);
    drive_item(REQ_POP_FRONT, '0, '0);
    drive_item(REQ_POP_BACK, '0, '0);
    drive_item(REQ_POP_BACK, '0, '0);
    drive_item(REQ_POP_FRONT, '0, '0);
    drive_item(REQ_REMOVE, '0, {INDEX_W{1'b1}});
    wait_drained();

    // fill past capacity, then drain past empty
    sent = 0;
    while (sb.slots.size() < SFBL_CAPACITY) begin
      random_item(REQ_INSERT);
      sent++;
      pace();
    end
    repeat (3) begin
      random_item(REQ_INSERT);
      sent++;
      pace();
    end
    while (sb.slots.size() > 0) begin
      random_item($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK);
      sent++;
      pace();
    end
    repeat (2) begin
      random_item($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK);
      sent++;
      pace();
    end
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      phase     = phase_t'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 150);
      if ($urandom_range(0, 3) == 0) wait_drained();
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        case (phase)
          PH_FILL:  rt = r < 80 ? REQ_INSERT : r < 88 ? REQ_POP_FRONT :
                         r < 94 ? REQ_POP_BACK : REQ_REMOVE;
          PH_DRAIN: rt = r < 15 ? REQ_INSERT : r < 50 ? REQ_POP_FRONT :
                         r < 80 ? REQ_POP_BACK : REQ_REMOVE;
          default:  rt = r < 45 ? REQ_INSERT : r < 60 ? REQ_POP_FRONT :
                         r < 75 ? REQ_POP_BACK : REQ_REMOVE;
        endcase
        random_item(rt);
        sent++;
        pace();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.pending()));

    $display("Run covered %0d inserts (%0d refused as full), %0d pops, %0d removes",
             sb.n_insert, sb.n_full, sb.n_pop, sb.n_remove);
    $display("%0d empty or not-found outcomes, peak occupancy %0d of %0d, %0d responses checked",
             sb.n_miss, sb.peak, SFBL_CAPACITY, sb.checked);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
